// File: hw/rtl/anti_replay_window_check_macros.svh
// ----------------------------------------------------------------------------
// Anti-replay window check: assertion macros
// Concurrent assertion wrappers used by the back-end RTL file (arwc_back).
// ----------------------------------------------------------------------------
`ifndef ANTI_REPLAY_WINDOW_CHECK_MACROS_SVH
`define ANTI_REPLAY_WINDOW_CHECK_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked outside reset
`define ARWC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every edge, reset included
`define ARWC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ARWC_ASSERT(label, clk, rst, prop, msg)
`define ARWC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// File: hw/rtl/arwc_pkg.sv
// ----------------------------------------------------------------------------
// Anti-replay window check package
// Sizes, verdict codes and the types passed between the front, queue and back.
// ----------------------------------------------------------------------------
`default_nettype none

package arwc_pkg;

   // Table geometry (LANES is a power of two)
   localparam int SESSIONS     = 256;
   localparam int LANES        = 16;
   localparam int LANE_SHIFT   = 48;
   localparam int WINDOW_WORDS = 4;

   // Field widths of the streams
   localparam int SESSION_W = 32;
   localparam int RAW_W     = 64;
   localparam int VERDICT_W = 2;
   localparam int LANE_W    = 4;
   localparam int COUNT_W   = 48;

   // Derived sizes
   localparam int SESSION_BITS = $clog2(SESSIONS);
   localparam int LANE_BITS    = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int PAIRS        = SESSIONS * LANES;
   localparam int PAIR_BITS    = $clog2(PAIRS);
   localparam int SEQ_W        = LANE_SHIFT;
   localparam int WINDOW_BITS  = WINDOW_WORDS * 64;
   localparam int DIST_BITS    = $clog2(WINDOW_BITS);

   // Decoupling queue
   localparam int QDEPTH    = 2;
   localparam int QPTR_BITS = $clog2(QDEPTH);
   localparam int QCNT_BITS = $clog2(QDEPTH + 1);

   // Stream packing
   localparam int REQ_DATA_W = ((SESSION_W + RAW_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((VERDICT_W + LANE_W + COUNT_W + 7) / 8) * 8;

   typedef enum logic [VERDICT_W-1:0] {
      VERDICT_ACCEPT  = 2'd0,
      VERDICT_REPLAY  = 2'd1,
      VERDICT_AUTH    = 2'd2,
      VERDICT_INVALID = 2'd3
   } verdict_type;

   // Classified item as queued between front and back
   typedef struct packed {
      logic                 session_ok;
      logic                 auth_ok;
      logic [PAIR_BITS-1:0] pair;
      logic [LANE_BITS-1:0] lane;
      logic [SEQ_W-1:0]     seq;
   } item_type;

   // Per-pair state word held in the table memory
   typedef struct packed {
      logic [SEQ_W-1:0]       highest;
      logic [WINDOW_BITS-1:0] seen;
   } pair_state_type;

endpackage

`default_nettype wire

// File: hw/rtl/arwc_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module arwc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/arwc_front.sv
// ----------------------------------------------------------------------------
// Anti-replay front end
// Accepts request items, decodes lane and count and classifies the session.
// ----------------------------------------------------------------------------
`default_nettype none

module arwc_front
   import arwc_pkg::*;
(
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // session_number, raw_sequence
   input  wire logic                  req_tuser,   // auth_ok
   input  wire logic                  clearing,
   input  wire logic                  queue_full,
   output logic                       push,
   output item_type                   push_item
);

   logic [SESSION_W-1:0] session;
   logic [RAW_W-1:0]     raw;

   assign session = req_tdata[SESSION_W-1:0];
   assign raw     = req_tdata[SESSION_W +: RAW_W];

   // No intake while the table is being cleared or the queue is full
   assign req_tready = !queue_full && !clearing;
   assign push       = req_tvalid && req_tready;

   // Decode and classify
   always_comb begin
      push_item.session_ok = (session != '0) && (session < SESSION_W'(SESSIONS));
      push_item.auth_ok    = req_tuser;
      push_item.lane       = raw[LANE_SHIFT +: LANE_BITS];
      push_item.seq        = raw[SEQ_W-1:0];
      push_item.pair       = {session[SESSION_BITS-1:0], raw[LANE_SHIFT +: LANE_BITS]};
   end

endmodule

`default_nettype wire

// File: hw/rtl/arwc_queue.sv
// ----------------------------------------------------------------------------
// Anti-replay item queue
// Short FIFO of classified items between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module arwc_queue
   import arwc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   input  wire logic     pop,
   output item_type      head_item,
   output logic          full,
   output logic          empty
);

   item_type               entry_ff [QDEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;

   assign full      = (count_ff == QCNT_BITS'(QDEPTH));
   assign empty     = (count_ff == '0);
   assign head_item = entry_ff[rd_ptr_ff];

   // Pointer and fill updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/arwc_back.sv
// ----------------------------------------------------------------------------
// Anti-replay back end
// Clears the pair table after reset, then per item reads the pair state (valid
// session), decides the verdict, commits accepted ones and hands the result out.
// ----------------------------------------------------------------------------
`default_nettype none
`include "anti_replay_window_check_macros.svh"

module arwc_back
   import arwc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire item_type              head_item,
   input  wire logic                  queue_empty,
   output logic                       pop,
   output logic                       clearing,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata    // verdict, sender_lane, sequence_count
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_EVAL,
      S_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [PAIR_BITS-1:0]   clr_ff, clr_in;
   item_type               item_ff, item_in;
   pair_state_type         cur_ff, cur_in;
   logic                   newer_ff, newer_in;
   logic                   far_ff, far_in;
   logic [DIST_BITS-1:0]   dist_ff, dist_in;
   verdict_type            verdict_ff, verdict_in;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0]  rsp_tdata_ff, rsp_tdata_in;

   logic                   ram_we;
   logic [PAIR_BITS-1:0]   ram_waddr;
   pair_state_type         ram_wdata;
   pair_state_type         ram_rdata;

   logic                   out_free;
   logic                   load_rsp;
   logic [SEQ_W:0]         diff_up;
   logic [SEQ_W-1:0]       diff_down;
   logic [SEQ_W-1:0]       dist_full;
   logic                   hit;
   verdict_type            eval_verdict;
   pair_state_type         commit;

   // Pair table
   arwc_ram #(
      .WIDTH ($bits(pair_state_type)),
      .DEPTH (PAIRS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (head_item.pair),
      .rd_data (ram_rdata)
   );

   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign clearing = (state_ff == S_CLEAR);
   assign pop      = (state_ff == S_IDLE) && !queue_empty;
   assign load_rsp = (state_ff == S_DONE) && out_free;

   // Distance between the stored highest count and this count
   always_comb begin
      diff_up   = {1'b0, item_ff.seq} - {1'b0, ram_rdata.highest};
      diff_down = ram_rdata.highest - item_ff.seq;
      newer_in  = !diff_up[SEQ_W] && (diff_up[SEQ_W-1:0] != '0);
      dist_full = newer_in ? diff_up[SEQ_W-1:0] : diff_down;
      far_in    = |dist_full[SEQ_W-1:DIST_BITS];
      dist_in   = dist_full[DIST_BITS-1:0];
      cur_in    = ram_rdata;
   end

   // Verdict and committed window
   always_comb begin
      hit = cur_ff.seen[dist_ff];
      if (!newer_ff && (far_ff || hit)) begin
         eval_verdict = VERDICT_REPLAY;
      end else if (!item_ff.auth_ok) begin
         eval_verdict = VERDICT_AUTH;
      end else begin
         eval_verdict = VERDICT_ACCEPT;
      end
      if (newer_ff) begin
         commit.highest = item_ff.seq;
         commit.seen    = far_ff ? '0 : (cur_ff.seen << dist_ff);
         commit.seen[0] = 1'b1;
      end else begin
         commit.highest = cur_ff.highest;
         commit.seen    = cur_ff.seen | (WINDOW_BITS'(1) << dist_ff);
      end
   end

   // Table write port: clearing pass or commit
   always_comb begin
      if (state_ff == S_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
         ram_wdata = '0;
      end else begin
         ram_we    = (state_ff == S_EVAL) && (eval_verdict == VERDICT_ACCEPT);
         ram_waddr = item_ff.pair;
         ram_wdata = commit;
      end
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      item_in       = item_ff;
      verdict_in    = verdict_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == PAIR_BITS'(PAIRS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (!queue_empty) begin
               item_in = head_item;
               if (head_item.session_ok) begin
                  state_in = S_READ;
               end else begin
                  verdict_in = VERDICT_INVALID;
                  state_in   = S_DONE;
               end
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            verdict_in = eval_verdict;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = RSP_DATA_W'({COUNT_W'(item_ff.seq),
                                            LANE_W'(item_ff.lane),
                                            verdict_ff});
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      item_ff      <= item_in;
      verdict_ff   <= verdict_in;
      rsp_tdata_ff <= rsp_tdata_in;
      cur_ff       <= cur_in;
      newer_ff     <= newer_in;
      far_ff       <= far_in;
      dist_ff      <= dist_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Checks
   `ARWC_ASSERT_ALWAYS(a_no_pop_in_clear, clock, clearing |-> !pop, "item taken during clear")
   `ARWC_ASSERT(a_read_after_pop, clock, reset,
      (state_ff == S_READ) |-> $past(pop), "table read without a popped item")
   `ARWC_ASSERT(a_rsp_not_lost, clock, reset,
      load_rsp |-> (!rsp_tvalid_ff || rsp_tready), "pending result overwritten")
   `ARWC_ASSERT(a_newer_marks_top, clock, reset,
      (ram_we && (state_ff == S_EVAL) && newer_ff) |-> ram_wdata.seen[0],
      "newest count not marked")
   `ARWC_ASSERT(a_reset_clears, clock, reset,
      $past(reset) |-> (state_ff == S_CLEAR) && (clr_ff == '0), "reset not restarting clear")

endmodule

`default_nettype wire

// File: hw/rtl/anti_replay_window_check.sv
// An accepted item waits in the queue until the back-end sequencer takes it
// through table read, evaluate/commit and result load (an invalid session skips
// read and evaluate); the result load waits for the output, then the next item.
// A 2-entry queue lets the front accept items while the back end works.
// Reset is synchronous, active high; afterwards the 4096-entry pair table is
// cleared one entry a cycle with req_tready held low.
// ----------------------------------------------------------------------------
// Anti-replay window check
// Per packet, checks the sequence count against a 256-bit sliding window kept
// for each session and sender lane, and commits authenticated non-replay packets.
// ----------------------------------------------------------------------------
`default_nettype none

module anti_replay_window_check
   import arwc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // session_number[31:0], raw_sequence[95:32]
   input  wire logic                  req_tuser,   // auth_ok
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata    // verdict[1:0], sender_lane[5:2],
                                                   // sequence_count[53:6], zero pad
);

   logic     push;
   item_type push_item;
   logic     pop;
   item_type head_item;
   logic     queue_full;
   logic     queue_empty;
   logic     clearing;

   arwc_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .clearing   (clearing),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   arwc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   arwc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_item   (head_item),
      .queue_empty (queue_empty),
      .pop         (pop),
      .clearing    (clearing),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

`default_nettype wire
